FILE: rtl/lwpc_pkg.sv
//------------------------------------------------------------------------------
// lwpc_pkg
// Shared types and constants for the page cache tag controller.
//------------------------------------------------------------------------------
package lwpc_pkg;
	localparam int SLOTS_DEF     = 16;
	localparam int FILE_BITS_DEF = 10;
	localparam int PAGE_BITS_DEF = 32;
	localparam int CAP_BITS      = 5;
	localparam int MAX_RES       = 16;

	localparam logic [1:0] MODE_GET   = 2'd0;
	localparam logic [1:0] MODE_DIRTY = 2'd1;
	localparam logic [1:0] MODE_SYNC  = 2'd2;
	localparam logic [1:0] MODE_FLUSH = 2'd3;

	localparam logic [0:0] REG_ACTIVE_SLOTS = 1'd0;
endpackage

FILE: rtl/lwpc_if.sv
//------------------------------------------------------------------------------
// lwpc_req_if / lwpc_rsp_if
// Valid/ready channels for requests and results.
//------------------------------------------------------------------------------
interface lwpc_req_if #(parameter int FB = 10, parameter int PB = 32);
	logic          valid;
	logic          ready;
	logic [1:0]    mode;
	logic [FB-1:0] file_id;
	logic [PB-1:0] page_number;
	logic [3:0]    slot_in;
	modport source (output valid, mode, file_id, page_number, slot_in, input ready);
	modport sink   (input valid, mode, file_id, page_number, slot_in, output ready);
endinterface

interface lwpc_rsp_if #(parameter int FB = 10, parameter int PB = 32);
	logic          valid;
	logic          ready;
	logic [3:0]    slot;
	logic          hit;
	logic          fill;
	logic          writeback;
	logic [FB-1:0] wb_file;
	logic [PB-1:0] wb_page;
	logic          last;
	modport source (output valid, slot, hit, fill, writeback, wb_file, wb_page, last,
		input ready);
	modport sink   (input valid, slot, hit, fill, writeback, wb_file, wb_page, last,
		output ready);
endinterface

FILE: rtl/lwpc_ram.sv
//------------------------------------------------------------------------------
// lwpc_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
module lwpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/lru_writeback_page_cache_tags.sv
//------------------------------------------------------------------------------
// lru_writeback_page_cache_tags
// Tag, dirty and LRU controller of a fully associative write-back page cache.
//------------------------------------------------------------------------------
// Requests are handled one at a time by a sequencer that walks all SLOTS
// entries of the tag RAM (registered read data) and updates per-slot valid,
// dirty and rank flops. A get scans for a match, a free slot and the LRU
// slot, then updates the flops, hands off the result and returns to idle;
// mark-dirty skips the scan and goes straight to the update. Sync and flush
// scan for dirty slots and hold each writeback until the next one or the
// end of the scan tells whether it is the last. Output stalls hold the
// sequencer.
// Tag RAM contents are only used for valid slots so the RAM needs no clear.
module lru_writeback_page_cache_tags #(
	parameter int SLOTS     = lwpc_pkg::SLOTS_DEF,
	parameter int FILE_BITS = lwpc_pkg::FILE_BITS_DEF,
	parameter int PAGE_BITS = lwpc_pkg::PAGE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lwpc_req_if.sink   req,
	lwpc_rsp_if.source rsp,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);
	localparam int SB = $clog2(SLOTS);
	localparam int RB = $clog2(SLOTS);
	localparam int TW = FILE_BITS + PAGE_BITS;

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_UPD, ST_WB, ST_OUT, ST_END} state_t;

	state_t                 state_q;
	logic [lwpc_pkg::CAP_BITS-1:0] cap_reg_q;
	logic [SLOTS-1:0]       valid_q, dirty_q;
	logic [RB-1:0]          rank_q [SLOTS];
	logic [SB:0]            used_q;
	logic [1:0]             mode_q;
	logic [FILE_BITS-1:0]   fid_q;
	logic [PAGE_BITS-1:0]   pg_q;
	logic [3:0]             sin_q;
	logic [SB:0]            idx_q;      // read address issued
	logic                   rd_s1;      // read data valid for idx_s1
	logic [SB-1:0]          idx_s1;
	logic                   hit_q, free_q, lru_ok_q, dirty_hit_q;
	logic [SB-1:0]          hit_slot_q, free_slot_q, lru_slot_q;
	logic [RB-1:0]          lru_rank_q;
	logic [TW-1:0]          lru_tag_q;
	logic [4:0]             nres_q;
	logic                   more_q;     // unsent dirty slots remain
	logic                   pend_q;     // writeback held, not yet sent
	logic                   fin_q;      // scan finished
	logic [SB-1:0]          resume_q;
	logic [SB-1:0]          wb_slot_q;
	logic [TW-1:0]          wb_tag_q;

	logic [TW-1:0] rdata;
	logic          we;
	logic [SB-1:0] waddr;
	logic [TW-1:0] wdata;
	logic [SB:0]   cap;
	logic [SB-1:0] tgt;

	lwpc_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_tags (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(idx_q[SB-1:0]), .rdata(rdata)
	);

	assign pready = 1'b1;
	assign prdata = {{(32-lwpc_pkg::CAP_BITS){1'b0}}, cap_reg_q};

	always_comb begin
		if (cap_reg_q == '0) begin
			cap = (SB+1)'(1);
		end else if (32'(cap_reg_q) > SLOTS) begin
			cap = (SB+1)'(SLOTS);
		end else begin
			cap = (SB+1)'(cap_reg_q);
		end
	end

	assign tgt   = hit_q ? hit_slot_q : (free_q ? free_slot_q : lru_slot_q);
	assign we    = (state_q == ST_UPD) && (mode_q == lwpc_pkg::MODE_GET) && !hit_q;
	assign waddr = tgt;
	assign wdata = {fid_q, pg_q};

	assign req.ready = (state_q == ST_IDLE);

	logic [FILE_BITS-1:0] rfile;
	logic [PAGE_BITS-1:0] rpage;
	logic                 rv, rd;
	logic                 wb_take;
	assign rfile = rdata[TW-1:PAGE_BITS];
	assign rpage = rdata[PAGE_BITS-1:0];
	assign rv    = valid_q[idx_s1];
	assign rd    = dirty_q[idx_s1];
	assign wb_take = (mode_q != lwpc_pkg::MODE_GET) && rv && rd &&
		(mode_q == lwpc_pkg::MODE_FLUSH || rfile == fid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cap_reg_q <= lwpc_pkg::CAP_BITS'(16);
			valid_q   <= '0;
			dirty_q   <= '0;
			used_q    <= '0;
			rd_s1     <= 1'b0;
			rsp.valid <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (psel && penable && pwrite &&
				paddr[2] == lwpc_pkg::REG_ACTIVE_SLOTS && paddr[1:0] == 2'd0) begin
				cap_reg_q <= pwdata[lwpc_pkg::CAP_BITS-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						mode_q      <= req.mode;
						fid_q       <= req.file_id;
						pg_q        <= req.page_number;
						sin_q       <= req.slot_in;
						idx_q       <= '0;
						rd_s1       <= 1'b0;
						hit_q       <= 1'b0;
						free_q      <= 1'b0;
						lru_ok_q    <= 1'b0;
						lru_slot_q  <= '0;
						lru_rank_q  <= '0;
						nres_q      <= '0;
						more_q      <= 1'b0;
						pend_q      <= 1'b0;
						fin_q       <= 1'b0;
						state_q     <= (req.mode == lwpc_pkg::MODE_DIRTY) ? ST_UPD : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q < (SB+1)'(SLOTS)) begin
						idx_s1 <= idx_q[SB-1:0];
						idx_q  <= idx_q + 1'b1;
						rd_s1  <= 1'b1;
					end else begin
						rd_s1 <= 1'b0;
					end
					if (rd_s1) begin
						if (mode_q == lwpc_pkg::MODE_GET) begin
							if (rv && rfile == fid_q && rpage == pg_q && !hit_q) begin
								hit_q      <= 1'b1;
								hit_slot_q <= idx_s1;
							end
							if (!rv && !free_q && used_q < cap && (SB+1)'(idx_s1) < cap) begin
								free_q      <= 1'b1;
								free_slot_q <= idx_s1;
							end
							if (rv && (!lru_ok_q || rank_q[idx_s1] > lru_rank_q)) begin
								lru_ok_q   <= 1'b1;
								lru_slot_q <= idx_s1;
								lru_rank_q <= rank_q[idx_s1];
								lru_tag_q  <= rdata;
							end
						end else if (wb_take) begin
							if (nres_q >= 5'(lwpc_pkg::MAX_RES)) begin
								more_q <= 1'b1;
							end else if (!pend_q) begin
								pend_q    <= 1'b1;
								wb_slot_q <= idx_s1;
								wb_tag_q  <= rdata;
								dirty_q[idx_s1] <= 1'b0;
								nres_q    <= nres_q + 1'b1;
							end else begin
								// send the held writeback, then rescan this slot
								resume_q <= idx_s1;
								state_q  <= ST_WB;
							end
						end
						if (idx_s1 == SB'(SLOTS-1) &&
							!(wb_take && pend_q && nres_q < 5'(lwpc_pkg::MAX_RES))) begin
							fin_q   <= 1'b1;
							state_q <= (mode_q == lwpc_pkg::MODE_GET) ? ST_UPD : ST_WB;
						end
					end
				end
				ST_WB: begin
					// hold the scan; present one writeback
					rd_s1 <= 1'b0;
					if (pend_q) begin
						pend_q        <= 1'b0;
						rsp.valid     <= 1'b1;
						rsp.slot      <= 4'(wb_slot_q);
						rsp.hit       <= 1'b0;
						rsp.fill      <= 1'b0;
						rsp.writeback <= 1'b1;
						rsp.wb_file   <= wb_tag_q[TW-1:PAGE_BITS];
						rsp.wb_page   <= wb_tag_q[PAGE_BITS-1:0];
						rsp.last      <= fin_q;
						state_q       <= ST_OUT;
					end else begin
						state_q <= ST_END;
					end
				end
				ST_OUT: begin
					if (rsp.ready) begin
						rsp.valid <= 1'b0;
						if (fin_q) begin
							state_q <= ST_END;
						end else begin
							idx_q   <= (SB+1)'(resume_q);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_UPD: begin
					if (mode_q == lwpc_pkg::MODE_DIRTY) begin
						state_q <= ST_IDLE;
						if (32'(sin_q) < SLOTS && valid_q[sin_q[SB-1:0]]) begin
							dirty_q[sin_q[SB-1:0]] <= 1'b1;
							for (int i = 0; i < SLOTS; i++) begin
								if (valid_q[i] && rank_q[i] < rank_q[sin_q[SB-1:0]]) begin
									rank_q[i] <= rank_q[i] + 1'b1;
								end
							end
							rank_q[sin_q[SB-1:0]] <= '0;
						end
					end else begin
						for (int i = 0; i < SLOTS; i++) begin
							if (valid_q[i] &&
								((!hit_q && free_q) || rank_q[i] < rank_q[tgt])) begin
								rank_q[i] <= rank_q[i] + 1'b1;
							end
						end
						rank_q[tgt] <= '0;
						rsp.valid     <= 1'b1;
						rsp.slot      <= 4'(tgt);
						rsp.hit       <= hit_q;
						rsp.fill      <= !hit_q;
						rsp.writeback <= !hit_q && !free_q && dirty_q[lru_slot_q];
						rsp.wb_file   <= (!hit_q && !free_q && dirty_q[lru_slot_q]) ?
							lru_tag_q[TW-1:PAGE_BITS] : '0;
						rsp.wb_page   <= (!hit_q && !free_q && dirty_q[lru_slot_q]) ?
							lru_tag_q[PAGE_BITS-1:0] : '0;
						rsp.last      <= 1'b1;
						if (!hit_q) begin
							dirty_q[tgt] <= 1'b0;
							if (free_q) begin
								valid_q[tgt] <= 1'b1;
								used_q       <= used_q + 1'b1;
							end
						end
						state_q <= ST_END;
					end
				end
				ST_END: begin
					// wait for the final result to be taken
					if (!rsp.valid || rsp.ready) begin
						rsp.valid <= 1'b0;
						state_q   <= ST_IDLE;
						if (mode_q == lwpc_pkg::MODE_FLUSH && !more_q) begin
							valid_q <= '0;
							dirty_q <= '0;
							used_q  <= '0;
							for (int i = 0; i < SLOTS; i++) begin
								rank_q[i] <= '0;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	property p_rsp_hold;
		@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable({rsp.slot, rsp.hit, rsp.fill,
			rsp.writeback, rsp.wb_file, rsp.wb_page, rsp.last});
	endproperty
	a_rsp_hold: assert property (p_rsp_hold);
	a_idle_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !rsp.valid);
	a_used_max: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= (SB+1)'(SLOTS));
	a_wb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.writeback |-> rsp.wb_file == '0 && rsp.wb_page == '0);
endmodule

FILE: test/lwpc_tb_pkg.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// lwpc_tb_pkg
// Predictor and checker for the page cache tag controller: tags, dirty bits,
// recency ranks and the results that each request should produce.
//------------------------------------------------------------------------------
package lwpc_tb_pkg;
	typedef struct packed {
		logic [3:0]  slot;
		logic        hit;
		logic        fill;
		logic        writeback;
		logic [9:0]  wb_file;
		logic [31:0] wb_page;
		logic        last;
	} cache_result_t;

	class cache_scoreboard;
		bit          valid_q [16];
		bit          dirty_q [16];
		bit [9:0]    ftag [16];
		bit [31:0]   ptag [16];
		int unsigned rank [16];
		int unsigned used;
		int unsigned active;
		cache_result_t pending[$];
		int errors;
		int results_seen;
		int hits;
		int evictions;
		int writebacks;

		function new();
			active = 16;
			used = 0;
			errors = 0;
			results_seen = 0;
			hits = 0;
			evictions = 0;
			writebacks = 0;
			for (int i = 0; i < 16; i++) begin
				valid_q[i] = 0;
				dirty_q[i] = 0;
				ftag[i] = '0;
				ptag[i] = '0;
				rank[i] = 0;
			end
		endfunction

		function int unsigned cap();
			if (active < 1) return 1;
			if (active > 16) return 16;
			return active;
		endfunction

		function void promote(int s);
			int unsigned r;
			r = rank[s];
			for (int i = 0; i < 16; i++)
				if (i != s && valid_q[i] && rank[i] < r) rank[i]++;
			rank[s] = 0;
		endfunction

		function void push(int s, bit h, bit f, bit w, bit [9:0] wf, bit [31:0] wp, bit l);
			cache_result_t r;
			r.slot = s[3:0];
			r.hit = h;
			r.fill = f;
			r.writeback = w;
			r.wb_file = w ? wf : '0;
			r.wb_page = w ? wp : '0;
			r.last = l;
			pending.push_back(r);
		endfunction

		function void lookup(bit [9:0] fid, bit [31:0] pg);
			int s;
			int unsigned best;
			bit w;
			for (int i = 0; i < 16; i++) begin
				if (valid_q[i] && ftag[i] == fid && ptag[i] == pg) begin
					promote(i);
					hits++;
					push(i, 1, 0, 0, '0, '0, 1);
					return;
				end
			end
			s = -1;
			if (used < cap())
				for (int i = 0; i < cap(); i++)
					if (!valid_q[i] && s < 0) s = i;
			if (s >= 0) begin
				for (int i = 0; i < 16; i++)
					if (valid_q[i]) rank[i]++;
				valid_q[s] = 1;
				used++;
				rank[s] = 0;
				dirty_q[s] = 0;
				ftag[s] = fid;
				ptag[s] = pg;
				push(s, 0, 1, 0, '0, '0, 1);
				return;
			end
			// oldest valid slot, lowest index on a tie
			s = -1;
			best = 0;
			for (int i = 0; i < 16; i++)
				if (valid_q[i] && (s < 0 || rank[i] > best)) begin
					s = i;
					best = rank[i];
				end
			w = dirty_q[s];
			evictions++;
			push(s, 0, 1, w, ftag[s], ptag[s], 1);
			promote(s);
			dirty_q[s] = 0;
			ftag[s] = fid;
			ptag[s] = pg;
		endfunction

		function bit flush_dirty(bit one_file, bit [9:0] fid);
			int n;
			bit done;
			n = 0;
			done = 1;
			for (int i = 0; i < 16; i++) begin
				if (!valid_q[i] || !dirty_q[i]) continue;
				if (one_file && ftag[i] != fid) continue;
				if (n >= lwpc_pkg::MAX_RES) begin
					done = 0;
					continue;
				end
				push(i, 0, 0, 1, ftag[i], ptag[i], 0);
				dirty_q[i] = 0;
				n++;
			end
			if (n > 0) pending[pending.size() - 1].last = 1;
			return done;
		endfunction

		function void note_request(bit [1:0] mode, bit [9:0] fid, bit [31:0] pg, bit [3:0] sl);
			case (mode)
				lwpc_pkg::MODE_GET: lookup(fid, pg);
				lwpc_pkg::MODE_DIRTY: begin
					if (valid_q[sl]) begin
						dirty_q[sl] = 1;
						promote(sl);
					end
				end
				lwpc_pkg::MODE_SYNC: void'(flush_dirty(1, fid));
				default: begin
					if (flush_dirty(0, '0)) begin
						for (int i = 0; i < 16; i++) begin
							valid_q[i] = 0;
							dirty_q[i] = 0;
							rank[i] = 0;
						end
						used = 0;
					end
				end
			endcase
		endfunction

		function bit check_result(cache_result_t got, output string msg);
			cache_result_t e;
			results_seen++;
			if (got.writeback) writebacks++;
			if (pending.size() == 0) begin
				msg = $sformatf("unexpected result %p", got);
				return 0;
			end
			e = pending.pop_front();
			if (got !== e) begin
				msg = $sformatf("got %p expected %p", got, e);
				return 0;
			end
			return 1;
		endfunction
	endclass
endpackage

FILE: test/testbench.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// testbench
// Drives get, mark-dirty, sync and flush requests into the page cache tag
// controller under several capacities, with random stalls on both channels.
//------------------------------------------------------------------------------
module testbench;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          cycles = 0;
	int          errors = 0;
	int          sent = 0;
	bit          idle_en = 1;
	bit          hold_sink = 0;
	bit          drain_done = 0;

	lwpc_req_if req ();
	lwpc_rsp_if rsp ();

	lwpc_tb_pkg::cache_scoreboard board;

	lru_writeback_page_cache_tags uut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	initial begin
		req.valid = 0;
		req.mode = lwpc_pkg::MODE_GET;
		req.file_id = '0;
		req.page_number = '0;
		req.slot_in = '0;
		rsp.ready = 0;
	end

	task automatic report(string msg);
		errors++;
		$display("mismatch @%0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side
	always @(posedge clk) begin
		string msg;
		lwpc_tb_pkg::cache_result_t r;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				r.slot = rsp.slot;
				r.hit = rsp.hit;
				r.fill = rsp.fill;
				r.writeback = rsp.writeback;
				r.wb_file = rsp.wb_file;
				r.wb_page = rsp.wb_page;
				r.last = rsp.last;
				if (!board.check_result(r, msg)) report(msg);
			end
		end
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) rsp.ready <= 0;
			else if (idle_en && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 3);
				rsp.ready <= 0;
				repeat (gap - 1) @(posedge clk);
				@(posedge clk);
				rsp.ready <= 1;
			end else rsp.ready <= 1;
		end
	end

	task automatic apb_write(logic [31:0] val);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {lwpc_pkg::REG_ACTIVE_SLOTS, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		board.active = val & 32'h1f;
	endtask

	task automatic send(logic [1:0] m, logic [9:0] f, logic [31:0] p, logic [3:0] s);
		int gap;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1;
		req.mode <= m;
		req.file_id <= f;
		req.page_number <= p;
		req.slot_in <= s;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		board.note_request(m, f, p, s);
		sent++;
	endtask

	task automatic quiesce();
		int t;
		req.valid <= 0;
		@(posedge clk);
		t = 0;
		while (board.pending.size() != 0 && t < 20000) begin
			@(posedge clk);
			t++;
		end
		repeat (40) @(posedge clk);
	endtask

	// mostly a small working set so hits, dirty evictions and syncs happen
	task automatic random_phase(int n);
		logic [1:0] m;
		logic [9:0] f;
		logic [31:0] p;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 55) m = lwpc_pkg::MODE_GET;
			else if (k < 80) m = lwpc_pkg::MODE_DIRTY;
			else if (k < 95) m = lwpc_pkg::MODE_SYNC;
			else m = lwpc_pkg::MODE_FLUSH;
			if ($urandom_range(0, 9) < 8) begin
				f = 10'($urandom_range(0, 3));
				p = $urandom_range(0, 11);
			end else begin
				f = 10'($urandom);
				p = $urandom;
			end
			send(m, f, p, 4'($urandom));
		end
	endtask

	initial begin
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: fill, hits, extremes, dirty, sync, eviction, flush
		send(lwpc_pkg::MODE_GET, 10'd0, 32'd0, 4'd0);
		send(lwpc_pkg::MODE_GET, 10'h3ff, 32'hffff_ffff, 4'd0);
		send(lwpc_pkg::MODE_GET, 10'd0, 32'd0, 4'd0);
		send(lwpc_pkg::MODE_DIRTY, 10'd0, 32'd0, 4'd1);
		send(lwpc_pkg::MODE_DIRTY, 10'd0, 32'd0, 4'd15);
		send(lwpc_pkg::MODE_SYNC, 10'h3ff, 32'd0, 4'd0);
		send(lwpc_pkg::MODE_SYNC, 10'h155, 32'd0, 4'd0);
		send(lwpc_pkg::MODE_DIRTY, 10'd0, 32'd0, 4'd0);
		send(lwpc_pkg::MODE_FLUSH, 10'd0, 32'd0, 4'd0);
		send(lwpc_pkg::MODE_FLUSH, 10'd0, 32'd0, 4'd0);
		quiesce();

		apb_write(32'd2);
		send(lwpc_pkg::MODE_GET, 10'd1, 32'haaaa_aaaa, 4'd0);
		send(lwpc_pkg::MODE_GET, 10'd2, 32'h5555_5555, 4'd0);
		send(lwpc_pkg::MODE_DIRTY, 10'd0, 32'd0, 4'd0);
		send(lwpc_pkg::MODE_GET, 10'd3, 32'd7, 4'd0);
		send(lwpc_pkg::MODE_GET, 10'd4, 32'd8, 4'd0);
		quiesce();

		// all 16 dirty then flush: maximal result burst
		apb_write(32'd16);
		for (int i = 0; i < 16; i++) send(lwpc_pkg::MODE_GET, 10'd9, i, 4'd0);
		quiesce();
		hold_sink = 1;
		fork
			begin
				repeat (250) @(posedge clk);
				hold_sink = 0;
			end
		join_none
		for (int i = 0; i < 16; i++) send(lwpc_pkg::MODE_DIRTY, 10'd0, 32'd0, i[3:0]);
		send(lwpc_pkg::MODE_FLUSH, 10'd0, 32'd0, 4'd0);
		for (int i = 0; i < 6; i++) send(lwpc_pkg::MODE_GET, 10'd5, i, 4'd0);
		send(lwpc_pkg::MODE_GET, 10'd6, 32'd6, 4'd0);
		quiesce();

		// shrink with slots above capacity still valid
		apb_write(32'd1);
		random_phase(40);
		quiesce();
		apb_write(32'd0);
		random_phase(30);
		quiesce();
		apb_write(32'd31);
		random_phase(50);
		quiesce();
		apb_write(32'd5);
		random_phase(50);
		quiesce();
		apb_write(32'd16);
		idle_en = 0;
		random_phase(40);
		quiesce();

		if (board.pending.size() != 0) report("results still expected at end");
		errors += 0;
		$display("%0d requests, %0d results: %0d hits, %0d evictions, %0d writebacks",
			sent, board.results_seen, board.hits, board.evictions, board.writebacks);
		$display("capacities 1, 0, 2, 5, 16 and 31 exercised with stalls on both sides");
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
